/* sv/arr_pkg.sv */
package arr_pkg;

    localparam int DEPTH_W     = 24;
    localparam int DENS_W      = 40;
    localparam int SUM_W       = 56;
    localparam int COUNT_W     = 13;
    localparam int DSUM_W      = 36;
    localparam int GAIN_W      = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 56;

    localparam int MAX_LINE_PIXELS_DEF = 4096;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam logic [1:0] SPLIT_RUNS  = 2'd0;
    localparam logic [1:0] SPLIT_LINE  = 2'd1;
    localparam logic [1:0] SPLIT_CELLS = 2'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SPLIT_MODE,
        CFG_DEPTH_THRESHOLD,
        CFG_CELL_WIDTH,
        CFG_SUM_IS_PRIMARY,
        CFG_USE_DENSITY_INPUT,
        CFG_MIN_DENSITY_GATE,
        CFG_DEPTH_TO_DENSITY_GAIN
    } cfg_index_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_sample;
        logic [DENS_W-1:0]  density_sample;
        logic               line_end;
    } pixel_t;

    typedef struct packed {
        logic [SUM_W-1:0]   primary_density;
        logic [SUM_W-1:0]   other_density;
        logic [DEPTH_W-1:0] peak_depth;
        logic [COUNT_W-1:0] pixel_count;
        logic               passes_gate;
    } absorber_t;

    typedef struct packed {
        logic [1:0]         split_mode;
        logic [DEPTH_W-1:0] depth_threshold;
        logic [COUNT_W-1:0] cell_width;
        logic               sum_is_primary;
        logic               use_density_input;
        logic [SUM_W-1:0]   min_density_gate;
        logic [GAIN_W-1:0]  depth_to_density_gain;
    } cfg_t;

    // accumulator contents of one closed absorber
    typedef struct packed {
        logic [SUM_W-1:0]   density_sum;
        logic [DENS_W-1:0]  density_max;
        logic [DEPTH_W-1:0] run_peak;
        logic [COUNT_W-1:0] run_length;
        logic [DSUM_W-1:0]  depth_sum;
    } snapshot_t;

endpackage

/* sv/absorber_run_reducer_core.sv */
// Absorber run reducer: one spectral pixel per input beat, at most one
// absorber result per pixel.
// in_valid/in_stall/in_data: pixel beats; accepted when in_valid and !in_stall.
// out_valid/out_stall/out_data: absorber beats; taken when out_valid and
// !out_stall.
// cfg_valid/cfg_ready/cfg_index/cfg_data: register writes, ready always high;
// write only while the block is idle.
// Throughput: one pixel per cycle while in_stall is low, set by the accumulator
// update in the front end. The result for the pixel that closes an absorber
// passes the queue write, partial-product stage, density select stage and
// output register before it appears on out_valid.
// When out_stall is held, the back pipeline freezes and the 4-entry queue
// fills; in_stall rises only when the queue is full.
// Reset clears the accumulators, queue and pipeline valids and loads the
// register defaults (threshold runs, cell width 1, density samples used).
module absorber_run_reducer_core #(
    parameter int MAX_LINE_PIXELS = arr_pkg::MAX_LINE_PIXELS_DEF,
    parameter int QUEUE_DEPTH     = arr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  arr_pkg::pixel_t                  in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output arr_pkg::absorber_t               out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [arr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [arr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import arr_pkg::*;

    cfg_t      cfg_reg;
    logic      accept;
    logic      push, pop, q_not_empty, q_full;
    snapshot_t push_data, pop_data;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.split_mode            <= SPLIT_RUNS;
            cfg_reg.depth_threshold       <= '0;
            cfg_reg.cell_width            <= COUNT_W'(1);
            cfg_reg.sum_is_primary        <= 1'b0;
            cfg_reg.use_density_input     <= 1'b1;
            cfg_reg.min_density_gate      <= '0;
            cfg_reg.depth_to_density_gain <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SPLIT_MODE:
                    cfg_reg.split_mode <= cfg_data[1:0];
                CFG_DEPTH_THRESHOLD:
                    cfg_reg.depth_threshold <= cfg_data[DEPTH_W-1:0];
                CFG_CELL_WIDTH:
                    cfg_reg.cell_width <= cfg_data[COUNT_W-1:0];
                CFG_SUM_IS_PRIMARY:
                    cfg_reg.sum_is_primary <= cfg_data[0];
                CFG_USE_DENSITY_INPUT:
                    cfg_reg.use_density_input <= cfg_data[0];
                CFG_MIN_DENSITY_GATE:
                    cfg_reg.min_density_gate <= cfg_data[SUM_W-1:0];
                CFG_DEPTH_TO_DENSITY_GAIN:
                    cfg_reg.depth_to_density_gain <= cfg_data[GAIN_W-1:0];
                default:
                    ;
            endcase
        end
    end

    arr_front #(
        .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .accept (accept),
        .pixel  (in_data),
        .push   (push),
        .snap   (push_data)
    );

    arr_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (push_data),
        .pop       (pop),
        .rd_data   (pop_data),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    arr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .src_valid (q_not_empty),
        .src_data  (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* sv/arr_front.sv */
module arr_front #(
    parameter int MAX_LINE_PIXELS = arr_pkg::MAX_LINE_PIXELS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  arr_pkg::cfg_t      cfg,
    input  logic               accept,
    input  arr_pkg::pixel_t    pixel,
    output logic               push,
    output arr_pkg::snapshot_t snap
);
    import arr_pkg::*;

    localparam int CapInt = (MAX_LINE_PIXELS > 8191) ? 8191 : MAX_LINE_PIXELS;
    localparam logic [COUNT_W-1:0] CountCap = COUNT_W'(CapInt);

    logic      in_run_reg, in_run_next;
    snapshot_t acc_reg, acc_next;

    logic [1:0]         mode;
    logic [COUNT_W-1:0] cell_w;
    logic               absorbs;
    logic               emit;
    snapshot_t          post;
    logic [SUM_W:0]     dens_sum_w;
    logic [DSUM_W:0]    depth_sum_w;

    always_comb
    begin
        mode = (cfg.split_mode == SPLIT_LINE || cfg.split_mode == SPLIT_CELLS)
               ? cfg.split_mode : SPLIT_RUNS;
        cell_w = (cfg.cell_width == '0) ? COUNT_W'(1) : cfg.cell_width;

        dens_sum_w  = {1'b0, acc_reg.density_sum} + (SUM_W+1)'(pixel.density_sample);
        depth_sum_w = {1'b0, acc_reg.depth_sum} + (DSUM_W+1)'(pixel.depth_sample);

        post.run_length  = (acc_reg.run_length < CountCap)
                           ? acc_reg.run_length + COUNT_W'(1) : acc_reg.run_length;
        post.run_peak    = (pixel.depth_sample > acc_reg.run_peak)
                           ? pixel.depth_sample : acc_reg.run_peak;
        post.density_max = (pixel.density_sample > acc_reg.density_max)
                           ? pixel.density_sample : acc_reg.density_max;
        post.density_sum = dens_sum_w[SUM_W] ? '1 : dens_sum_w[SUM_W-1:0];
        post.depth_sum   = depth_sum_w[DSUM_W] ? '1 : depth_sum_w[DSUM_W-1:0];

        absorbs     = pixel.depth_sample > cfg.depth_threshold;
        emit        = 1'b0;
        snap        = post;
        in_run_next = in_run_reg;
        acc_next    = acc_reg;

        unique case (mode)
            SPLIT_LINE:
            begin
                emit = pixel.line_end;
                if (pixel.line_end)
                begin
                    in_run_next = 1'b0;
                    acc_next    = '0;
                end
                else
                begin
                    in_run_next = 1'b1;
                    acc_next    = post;
                end
            end
            SPLIT_CELLS:
            begin
                emit = post.run_length >= cell_w;
                if (emit || pixel.line_end)
                begin
                    in_run_next = 1'b0;
                    acc_next    = '0;
                end
                else
                begin
                    in_run_next = 1'b1;
                    acc_next    = post;
                end
            end
            default:
            begin
                if (absorbs)
                begin
                    emit = pixel.line_end;
                    if (pixel.line_end)
                    begin
                        in_run_next = 1'b0;
                        acc_next    = '0;
                    end
                    else
                    begin
                        in_run_next = 1'b1;
                        acc_next    = post;
                    end
                end
                else if (in_run_reg)
                begin
                    // run closes on this pixel, which is not part of it
                    emit        = 1'b1;
                    snap        = acc_reg;
                    in_run_next = 1'b0;
                    acc_next    = '0;
                end
            end
        endcase

        push = accept && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else if (accept)
        begin
            in_run_reg <= in_run_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

/* sv/arr_queue.sv */
module arr_queue #(
    parameter int DEPTH = arr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  arr_pkg::snapshot_t wr_data,
    input  logic               pop,
    output arr_pkg::snapshot_t rd_data,
    output logic               not_empty,
    output logic               full
);
    import arr_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    snapshot_t       entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg, count_next;

    assign not_empty = count_reg != '0;
    assign full      = count_reg == FullCnt;
    assign rd_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CntW'(1);
        else if (pop && !push)
            count_next = count_reg - CntW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

/* sv/arr_back.sv */
module arr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  arr_pkg::cfg_t      cfg,
    input  logic               src_valid,
    input  arr_pkg::snapshot_t src_data,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output arr_pkg::absorber_t out_data
);
    import arr_pkg::*;

    localparam int HalfW = GAIN_W / 2;
    localparam int ProdW = DSUM_W + HalfW;
    localparam int WideW = DSUM_W + GAIN_W + 1;
    localparam int FracW = 28;
    localparam logic [WideW-1:0] Round = WideW'(1) << (FracW - 1);

    logic adv;

    logic             s1_valid_reg;
    snapshot_t        s1_snap_reg;
    logic [ProdW-1:0] s1_hi_reg, s1_lo_reg;

    logic               s2_valid_reg;
    logic [SUM_W-1:0]   s2_prim_reg, s2_oth_reg;
    logic [DEPTH_W-1:0] s2_peak_reg;
    logic [COUNT_W-1:0] s2_count_reg;

    logic      out_valid_reg;
    absorber_t out_data_reg;

    logic [WideW-1:0] wide_sum;
    logic [SUM_W-1:0] derived;
    logic [SUM_W-1:0] prim_next, oth_next;

    // whole pipe moves as one; holds only while a result waits
    assign adv = !out_valid_reg || !out_stall;
    assign pop = adv && src_valid;

    always_comb
    begin
        wide_sum = WideW'({s1_hi_reg, {HalfW{1'b0}}}) + WideW'(s1_lo_reg) + Round;
        // at most 40 significant bits, never reaches the 56-bit limit
        derived  = SUM_W'(wide_sum[WideW-1:FracW]);
        if (cfg.use_density_input)
        begin
            if (cfg.sum_is_primary)
            begin
                prim_next = s1_snap_reg.density_sum;
                oth_next  = SUM_W'(s1_snap_reg.density_max);
            end
            else
            begin
                prim_next = SUM_W'(s1_snap_reg.density_max);
                oth_next  = s1_snap_reg.density_sum;
            end
        end
        else
        begin
            prim_next = derived;
            oth_next  = derived;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= src_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_snap_reg <= src_data;
            s1_hi_reg   <= ProdW'(src_data.depth_sum)
                         * ProdW'(cfg.depth_to_density_gain[GAIN_W-1:HalfW]);
            s1_lo_reg   <= ProdW'(src_data.depth_sum)
                         * ProdW'(cfg.depth_to_density_gain[HalfW-1:0]);

            s2_prim_reg  <= prim_next;
            s2_oth_reg   <= oth_next;
            s2_peak_reg  <= s1_snap_reg.run_peak;
            s2_count_reg <= s1_snap_reg.run_length;

            out_data_reg.primary_density <= s2_prim_reg;
            out_data_reg.other_density   <= s2_oth_reg;
            out_data_reg.peak_depth      <= s2_peak_reg;
            out_data_reg.pixel_count     <= s2_count_reg;
            out_data_reg.passes_gate     <= s2_prim_reg > cfg.min_density_gate;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* test/absorber_run_reducer_core_test.sv */
`timescale 1ns / 1ps

module absorber_run_reducer_core_test;
    import arr_pkg::*;

    localparam int COUNT_CAP    = MAX_LINE_PIXELS_DEF < 8191 ? MAX_LINE_PIXELS_DEF : 8191;
    localparam int RANDOM_ITEMS = 1500;
    localparam int TAIL_LEN     = 150;
    localparam int TAIL_CELL    = 64;
    localparam int SETTLE       = 10;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef enum logic [1:0] {
        ROW_REG,
        ROW_PIXEL,
        ROW_PIXEL_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        cfg_index_t            index;
        logic [CFG_DATA_W-1:0] value;
        pixel_t                pixel;
        absorber_t             known;
    } row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    pixel_t                 in_data;
    logic                   out_valid;
    logic                   out_stall;
    absorber_t              out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // register mirror and absorber accumulators
    cfg_t               shadow;
    bit                 run_open;
    logic [COUNT_W-1:0] run_len;
    logic [DEPTH_W-1:0] run_peak;
    logic [DENS_W-1:0]  dens_max;
    logic [SUM_W-1:0]   dens_sum;
    logic [DSUM_W-1:0]  depth_acc;

    absorber_t awaited_absorbers[$];
    row_t      directed_rows[$];
    int        mismatch_count = 0;
    int        pixels_sent = 0;
    int        cycle_count = 0;
    int        send_idle_pct = 18;
    int        recv_stall_pct = 75;

    absorber_run_reducer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void clear_run();
        run_open  = 1'b0;
        run_len   = '0;
        run_peak  = '0;
        dens_max  = '0;
        dens_sum  = '0;
        depth_acc = '0;
    endfunction

    function automatic void accumulate(input pixel_t p);
        logic [SUM_W:0]  s;
        logic [DSUM_W:0] t;
        run_open = 1'b1;
        if (run_len < COUNT_CAP)
            run_len = run_len + 1'b1;
        if (p.depth_sample > run_peak)
            run_peak = p.depth_sample;
        if (p.density_sample > dens_max)
            dens_max = p.density_sample;
        s = {1'b0, dens_sum} + (SUM_W + 1)'(p.density_sample);
        dens_sum = s[SUM_W] ? '1 : s[SUM_W-1:0];
        t = {1'b0, depth_acc} + (DSUM_W + 1)'(p.depth_sample);
        depth_acc = t[DSUM_W] ? '1 : t[DSUM_W-1:0];
    endfunction

    // Returns 1 when the pixel closes an absorber; its summary goes to a.
    function automatic bit reduce_pixel(input pixel_t p, output absorber_t a);
        logic [1:0]         mode;
        logic [COUNT_W-1:0] width;
        logic [68:0]        quot;
        logic [SUM_W-1:0]   prim;
        logic [SUM_W-1:0]   oth;
        bit                 closes;
        mode = (shadow.split_mode == SPLIT_LINE || shadow.split_mode == SPLIT_CELLS) ?
               shadow.split_mode : SPLIT_RUNS;
        width = shadow.cell_width == '0 ? 13'd1 : shadow.cell_width;
        closes = 1'b0;
        a = '0;
        case (mode)
            SPLIT_LINE:
            begin
                accumulate(p);
                closes = p.line_end;
            end
            SPLIT_CELLS:
            begin
                accumulate(p);
                if (run_len >= width)
                    closes = 1'b1;
                else if (p.line_end)
                    clear_run();
            end
            default:
            begin
                if (p.depth_sample > shadow.depth_threshold)
                begin
                    accumulate(p);
                    closes = p.line_end;
                end
                else
                    closes = run_open;
            end
        endcase
        if (closes)
        begin
            if (shadow.use_density_input)
            begin
                prim = shadow.sum_is_primary ? dens_sum : SUM_W'(dens_max);
                oth  = shadow.sum_is_primary ? SUM_W'(dens_max) : dens_sum;
            end
            else
            begin
                // Q16.16 gain on a Q12.12 sum: drop 28 bits, round half up
                quot = (69'(depth_acc) * 69'(shadow.depth_to_density_gain)
                        + (69'(1) << 27)) >> 28;
                prim = |quot[68:SUM_W] ? '1 : quot[SUM_W-1:0];
                oth  = prim;
            end
            a.primary_density = prim;
            a.other_density   = oth;
            a.peak_depth      = run_peak;
            a.pixel_count     = run_len;
            a.passes_gate     = prim > shadow.min_density_gate;
            clear_run();
        end
        return closes;
    endfunction

    function automatic void apply_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
        case (idx)
            CFG_SPLIT_MODE:            shadow.split_mode = v[1:0];
            CFG_DEPTH_THRESHOLD:       shadow.depth_threshold = v[DEPTH_W-1:0];
            CFG_CELL_WIDTH:            shadow.cell_width = v[COUNT_W-1:0];
            CFG_SUM_IS_PRIMARY:        shadow.sum_is_primary = v[0];
            CFG_USE_DENSITY_INPUT:     shadow.use_density_input = v[0];
            CFG_MIN_DENSITY_GATE:      shadow.min_density_gate = v[SUM_W-1:0];
            CFG_DEPTH_TO_DENSITY_GAIN: shadow.depth_to_density_gain = v[GAIN_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void check_absorber(input absorber_t got);
        absorber_t want;
        if (awaited_absorbers.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected absorber beat: prim %h oth %h peak %h cnt %0d gate %0b",
                         got.primary_density, got.other_density, got.peak_depth,
                         got.pixel_count, got.passes_gate);
            return;
        end
        want = awaited_absorbers.pop_front();
        if (got.primary_density !== want.primary_density
            || got.other_density !== want.other_density
            || got.peak_depth !== want.peak_depth
            || got.pixel_count !== want.pixel_count
            || got.passes_gate !== want.passes_gate)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("absorber mismatch: want prim %h oth %h peak %h cnt %0d gate %0b",
                         want.primary_density, want.other_density, want.peak_depth,
                         want.pixel_count, want.passes_gate);
                $display("                    got prim %h oth %h peak %h cnt %0d gate %0b",
                         got.primary_density, got.other_density, got.peak_depth,
                         got.pixel_count, got.passes_gate);
            end
        end
    endfunction

    // sampled right after the edge, so these are the values the block saw
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_absorber(out_data);
        out_stall <= $urandom_range(0, 99) < recv_stall_pct;
    end

    task automatic send_pixel(input pixel_t p, input bit use_known, input absorber_t known);
        absorber_t predicted;
        bit        produced;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do
            @(posedge clk);
        while (in_stall);
        pixels_sent++;
        produced = reduce_pixel(p, predicted);
        if (use_known)
            awaited_absorbers.insert(awaited_absorbers.size(), known);
        else if (produced)
            awaited_absorbers.insert(awaited_absorbers.size(), predicted);
    endtask

    // wait out every pending absorber plus the pipeline depth
    task automatic drain();
        in_valid <= 1'b0;
        while (awaited_absorbers.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // leaves cfg_valid high; caller lowers it after the last write of a group
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, v);
    endtask

    task automatic write_setup(input cfg_t c);
        write_reg(CFG_SPLIT_MODE, CFG_DATA_W'(c.split_mode));
        write_reg(CFG_DEPTH_THRESHOLD, CFG_DATA_W'(c.depth_threshold));
        write_reg(CFG_CELL_WIDTH, CFG_DATA_W'(c.cell_width));
        write_reg(CFG_SUM_IS_PRIMARY, CFG_DATA_W'(c.sum_is_primary));
        write_reg(CFG_USE_DENSITY_INPUT, CFG_DATA_W'(c.use_density_input));
        write_reg(CFG_MIN_DENSITY_GATE, CFG_DATA_W'(c.min_density_gate));
        write_reg(CFG_DEPTH_TO_DENSITY_GAIN, CFG_DATA_W'(c.depth_to_density_gain));
        cfg_valid <= 1'b0;
    endtask

    task automatic write_random_setup();
        cfg_t c;
        c.split_mode = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0:       c.depth_threshold = '0;
            1:       c.depth_threshold = '1;
            2:       c.depth_threshold = DEPTH_W'($urandom_range(0, 4095));
            default: c.depth_threshold = DEPTH_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       c.cell_width = COUNT_W'($urandom);
            1, 2:    c.cell_width = COUNT_W'($urandom_range(7, 40));
            default: c.cell_width = COUNT_W'($urandom_range(0, 6));
        endcase
        c.sum_is_primary    = 1'($urandom);
        c.use_density_input = 1'($urandom);
        case ($urandom_range(0, 4))
            0:       c.min_density_gate = '0;
            1:       c.min_density_gate = '1;
            2:       c.min_density_gate = SUM_W'({$urandom, $urandom});
            default: c.min_density_gate = SUM_W'({$urandom, $urandom}) >> $urandom_range(8, 24);
        endcase
        case ($urandom_range(0, 3))
            0:       c.depth_to_density_gain = '0;
            1:       c.depth_to_density_gain = '1;
            default: c.depth_to_density_gain = GAIN_W'($urandom);
        endcase
        write_setup(c);
    endtask

    // depths cluster on both sides of the threshold so runs open and close
    function automatic logic [DEPTH_W-1:0] pick_depth();
        int unsigned thr;
        thr = shadow.depth_threshold;
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return '1;
            2:          return DEPTH_W'($urandom);
            3, 4, 5:    return DEPTH_W'($urandom_range(0, thr));
            default:    return thr == 24'hFFFFFF ? '1 : DEPTH_W'($urandom_range(thr + 1, 24'hFFFFFF));
        endcase
    endfunction

    function automatic logic [DENS_W-1:0] pick_density();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return DENS_W'($urandom_range(0, 1000));
            default: return DENS_W'({$urandom, $urandom});
        endcase
    endfunction

    task automatic send_line(input int len, input bit at_max, input bit terminate);
        pixel_t p;
        for (int k = 0; k < len; k++)
        begin
            p.depth_sample   = at_max ? '1 : pick_depth();
            p.density_sample = at_max ? '1 : pick_density();
            p.line_end = k == len - 1 ? terminate : (!at_max && $urandom_range(0, 29) == 0);
            send_pixel(p, 1'b0, '0);
        end
    endtask

    function automatic void add_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
        row_t r;
        r = '0;
        r.kind  = ROW_REG;
        r.index = idx;
        r.value = v;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic void add_pixel(input logic [DEPTH_W-1:0] d,
                                      input logic [DENS_W-1:0] n, input bit last);
        row_t r;
        r = '0;
        r.kind  = ROW_PIXEL;
        r.pixel = '{depth_sample: d, density_sample: n, line_end: last};
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic void add_known(input logic [DEPTH_W-1:0] d, input logic [DENS_W-1:0] n,
                                      input bit last, input logic [SUM_W-1:0] prim,
                                      input logic [SUM_W-1:0] oth,
                                      input logic [DEPTH_W-1:0] peak,
                                      input logic [COUNT_W-1:0] cnt, input bit gate);
        row_t r;
        r = '0;
        r.kind  = ROW_PIXEL_KNOWN;
        r.pixel = '{depth_sample: d, density_sample: n, line_end: last};
        r.known = '{primary_density: prim, other_density: oth, peak_depth: peak,
                    pixel_count: cnt, passes_gate: gate};
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    initial
    begin
        int   start;
        int   len;
        cfg_t c;

        shadow = '{split_mode: SPLIT_RUNS, depth_threshold: '0, cell_width: 13'd1,
                   sum_is_primary: 1'b0, use_density_input: 1'b1,
                   min_density_gate: '0, depth_to_density_gain: '0};
        clear_run();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;

        // reset setup: runs above depth 0, primary is the maximum, gate 0
        add_pixel(24'h0, 40'h55, 1'b0);
        add_pixel(24'h1, 40'h5, 1'b0);
        add_pixel('1, '1, 1'b0);
        add_known(24'h0, 40'h0, 1'b0, 56'hFF_FFFF_FFFF, 56'h100_0000_0004, '1, 13'd2, 1'b1);
        add_known(24'h7, 40'h0, 1'b1, 56'h0, 56'h0, 24'h7, 13'd1, 1'b0);
        add_pixel(24'h0, 40'h0, 1'b1);
        add_pixel(24'h3, 40'h9, 1'b0);
        add_known(24'h0, '1, 1'b1, 56'h9, 56'h9, 24'h3, 13'd1, 1'b1);
        // top threshold: nothing absorbs
        add_reg(CFG_DEPTH_THRESHOLD, 56'hFF_FFFF);
        add_pixel('1, '1, 1'b1);
        // unused mode code behaves as runs; gate at its top never passes
        add_reg(CFG_SPLIT_MODE, 56'h3);
        add_reg(CFG_DEPTH_THRESHOLD, 56'h100);
        add_reg(CFG_SUM_IS_PRIMARY, 56'h1);
        add_reg(CFG_MIN_DENSITY_GATE, '1);
        add_pixel(24'h101, 40'h2, 1'b0);
        add_known(24'h100, 40'h0, 1'b0, 56'h2, 56'h2, 24'h101, 13'd1, 1'b0);
        // whole sightline
        add_reg(CFG_SPLIT_MODE, CFG_DATA_W'(SPLIT_LINE));
        add_reg(CFG_MIN_DENSITY_GATE, 56'h0);
        add_pixel(24'h0, 40'h1, 1'b0);
        add_pixel(24'h5, 40'h3, 1'b1);
        // cells: width 0 acts as 1, then 3 with a dropped partial cell
        add_reg(CFG_SPLIT_MODE, CFG_DATA_W'(SPLIT_CELLS));
        add_reg(CFG_CELL_WIDTH, 56'h0);
        add_known(24'h2, 40'h4, 1'b0, 56'h4, 56'h4, 24'h2, 13'd1, 1'b1);
        add_reg(CFG_CELL_WIDTH, 56'h3);
        add_pixel(24'h800, 40'h12_3456_789A, 1'b0);
        add_pixel(24'hABCDEF, 40'h7, 1'b0);
        add_pixel(24'h10, 40'hFF_0000_0000, 1'b0);
        add_pixel(24'h1, 40'h1, 1'b0);
        add_pixel(24'h2, 40'h2, 1'b1);
        // cell wider than any line never completes
        add_reg(CFG_CELL_WIDTH, 56'h1FFF);
        add_pixel(24'h55, 40'h66, 1'b0);
        add_pixel(24'h77, 40'h88, 1'b1);
        // densities derived from depth
        add_reg(CFG_SPLIT_MODE, CFG_DATA_W'(SPLIT_LINE));
        add_reg(CFG_USE_DENSITY_INPUT, 56'h0);
        add_reg(CFG_DEPTH_TO_DENSITY_GAIN, 56'hFFFF_FFFF);
        add_pixel(24'h1000, 40'h9, 1'b0);
        add_pixel(24'h800, 40'h9, 1'b1);
        add_reg(CFG_DEPTH_TO_DENSITY_GAIN, 56'h0);
        add_known('1, '1, 1'b1, 56'h0, 56'h0, '1, 13'd1, 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                if (i == 0 || directed_rows[i-1].kind != ROW_REG)
                    drain();
                write_reg(directed_rows[i].index, directed_rows[i].value);
                if (i == directed_rows.size() - 1 || directed_rows[i+1].kind != ROW_REG)
                    cfg_valid <= 1'b0;
            end
            else
                send_pixel(directed_rows[i].pixel, directed_rows[i].kind == ROW_PIXEL_KNOWN,
                           directed_rows[i].known);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct  = phase == 0 ? 18 : (phase == 1 ? 75 : 0);
            recv_stall_pct = phase == 0 ? 75 : (phase == 1 ? 18 : 0);
            start = pixels_sent;
            while (pixels_sent - start < RANDOM_ITEMS / 3)
            begin
                drain();
                write_random_setup();
                repeat ($urandom_range(1, 6))
                begin
                    len = $urandom_range(0, 9) == 0 ? $urandom_range(13, 48) : $urandom_range(1, 12);
                    // some lines stay open across the next register update
                    send_line(len, 1'b0, $urandom_range(0, 4) != 0);
                end
            end
        end

        // full-scale lines: large density sums, derived density, cells with a dropped tail
        drain();
        c = '{split_mode: SPLIT_LINE, depth_threshold: '0, cell_width: 13'd1,
              sum_is_primary: 1'b1, use_density_input: 1'b1,
              min_density_gate: '0, depth_to_density_gain: '0};
        write_setup(c);
        send_line(TAIL_LEN, 1'b1, 1'b1);
        drain();
        c.use_density_input     = 1'b0;
        c.depth_to_density_gain = '1;
        write_setup(c);
        send_line(TAIL_LEN, 1'b1, 1'b1);
        drain();
        c.split_mode        = SPLIT_CELLS;
        c.cell_width        = 13'(TAIL_CELL);
        c.use_density_input = 1'b1;
        c.sum_is_primary    = 1'b0;
        write_setup(c);
        send_line(2 * TAIL_CELL + 5, 1'b1, 1'b1);
        drain();

        if (mismatch_count == 0 && awaited_absorbers.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
